FILE: rtl/two_axis_servo_slew_limiter_defines.svh
// Assertion macros for the two-axis servo slew limiter.
// Used by the top level only; needs clock and reset in scope.
`ifndef TWO_AXIS_SERVO_SLEW_LIMITER_DEFINES_SVH
`define TWO_AXIS_SERVO_SLEW_LIMITER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TASSL_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TASSL_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tassl_pkg.sv
// Shared types, codes and reset values for the two-axis servo slew limiter.
// No dependencies; used by every RTL module of the block.
package tassl_pkg;

   localparam int unsigned NumAxes       = 2;
   localparam int unsigned AngleWidth    = 8;
   localparam int unsigned StepWidth     = 7;
   localparam int unsigned NudgeWidth    = 8;
   localparam int unsigned CmdWidth      = 9;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;

   typedef logic [AngleWidth-1:0] angle_type;
   typedef logic [StepWidth-1:0]  step_type;

   // Reset values of state and registers
   localparam angle_type ResetAngle  = 8'd90;
   localparam angle_type ResetMinA   = 8'd18;
   localparam angle_type ResetMaxA   = 8'd162;
   localparam angle_type ResetOffA   = 8'd18;
   localparam angle_type ResetMinB   = 8'd90;
   localparam angle_type ResetMaxB   = 8'd180;
   localparam angle_type ResetOffB   = 8'd0;
   localparam step_type  ResetStep   = 7'd1;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_SET   = 2'd1,
      ACT_NUDGE = 2'd2
   } action_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_A     = 3'd0,
      CSR_MAX_A     = 3'd1,
      CSR_OFFSET_A  = 3'd2,
      CSR_MIN_B     = 3'd3,
      CSR_MAX_B     = 3'd4,
      CSR_OFFSET_B  = 3'd5,
      CSR_SLEW_STEP = 3'd6
   } csr_index_type;

   typedef struct packed {
      angle_type min_angle;
      angle_type max_angle;
      angle_type offset;
   } axis_cfg_type;

   typedef struct packed {
      axis_cfg_type [NumAxes-1:0] axis;
      step_type                   slew_step;
   } cfg_type;

   typedef struct packed {
      logic                emit;
      angle_type           position;
      angle_type           target;
      logic [CmdWidth-1:0] command_angle;
   } step_result_type;

endpackage

FILE: rtl/tassl_csr.sv
// Configuration registers of the servo slew limiter: windows, offsets, step.
// Depends on tassl_pkg.
module tassl_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tassl_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tassl_pkg::CsrDataWidth-1:0]    csr_write_data,
   output tassl_pkg::cfg_type                    cfg
);

   tassl_pkg::cfg_type cfg_ff;
   tassl_pkg::cfg_type cfg_in;

   // Decode a write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (tassl_pkg::csr_index_type'(csr_index))
            tassl_pkg::CSR_MIN_A:     cfg_in.axis[0].min_angle = csr_write_data;
            tassl_pkg::CSR_MAX_A:     cfg_in.axis[0].max_angle = csr_write_data;
            tassl_pkg::CSR_OFFSET_A:  cfg_in.axis[0].offset    = csr_write_data;
            tassl_pkg::CSR_MIN_B:     cfg_in.axis[1].min_angle = csr_write_data;
            tassl_pkg::CSR_MAX_B:     cfg_in.axis[1].max_angle = csr_write_data;
            tassl_pkg::CSR_OFFSET_B:  cfg_in.axis[1].offset    = csr_write_data;
            tassl_pkg::CSR_SLEW_STEP:
               cfg_in.slew_step = csr_write_data[tassl_pkg::StepWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis[0].min_angle <= tassl_pkg::ResetMinA;
         cfg_ff.axis[0].max_angle <= tassl_pkg::ResetMaxA;
         cfg_ff.axis[0].offset    <= tassl_pkg::ResetOffA;
         cfg_ff.axis[1].min_angle <= tassl_pkg::ResetMinB;
         cfg_ff.axis[1].max_angle <= tassl_pkg::ResetMaxB;
         cfg_ff.axis[1].offset    <= tassl_pkg::ResetOffB;
         cfg_ff.slew_step         <= tassl_pkg::ResetStep;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/tassl_step.sv
// Per-request update of one axis: set, nudge or tick, plus the servo command.
// Pure combinational logic; depends on tassl_pkg.
module tassl_step (
   input  logic [1:0]                            action,
   input  tassl_pkg::angle_type                  request,
   input  logic signed [tassl_pkg::NudgeWidth-1:0] nudge,
   input  tassl_pkg::axis_cfg_type               axis_cfg,
   input  tassl_pkg::step_type                   slew_step,
   input  tassl_pkg::angle_type                  cur_angle,
   input  tassl_pkg::angle_type                  tgt_angle,
   output tassl_pkg::step_result_type            result
);

   logic signed [15:0] product;
   logic signed [16:0] moved;
   logic signed [16:0] max_wide;
   logic signed [16:0] min_wide;
   tassl_pkg::angle_type set_clamped;
   tassl_pkg::angle_type nudge_clamped;
   logic signed [9:0]  gap;
   logic signed [9:0]  step_wide;
   logic [8:0]         up;
   logic signed [9:0]  down;
   tassl_pkg::angle_type tick_angle;

   // Clamp a requested target into the window, max tested first
   always_comb begin
      if (request > axis_cfg.max_angle) begin
         set_clamped = axis_cfg.max_angle;
      end else if (request < axis_cfg.min_angle) begin
         set_clamped = axis_cfg.min_angle;
      end else begin
         set_clamped = request;
      end
   end

   // Shift the target by nudge steps, wide enough that nothing wraps
   always_comb begin
      product  = $signed(nudge) * $signed({1'b0, slew_step});
      moved    = {product[15], product} + {9'b0, tgt_angle};
      max_wide = $signed({9'b0, axis_cfg.max_angle});
      min_wide = $signed({9'b0, axis_cfg.min_angle});
      if (moved > max_wide) begin
         nudge_clamped = axis_cfg.max_angle;
      end else if (moved < min_wide) begin
         nudge_clamped = axis_cfg.min_angle;
      end else begin
         nudge_clamped = moved[7:0];
      end
   end

   // Step the current angle toward the target, or snap when close
   always_comb begin
      gap       = $signed({2'b0, tgt_angle}) - $signed({2'b0, cur_angle});
      step_wide = $signed({3'b0, slew_step});
      up        = {1'b0, cur_angle} + {2'b0, slew_step};
      down      = $signed({2'b0, cur_angle}) - step_wide;
      if (gap > step_wide) begin
         tick_angle = (up > {1'b0, axis_cfg.max_angle}) ? axis_cfg.max_angle : up[7:0];
      end else if (gap < -step_wide) begin
         tick_angle = (down < $signed({2'b0, axis_cfg.min_angle})) ?
                      axis_cfg.min_angle : down[7:0];
      end else begin
         tick_angle = tgt_angle;
      end
   end

   // Select the outcome by action; unused codes hold state and emit nothing
   always_comb begin
      result.emit     = 1'b0;
      result.position = cur_angle;
      result.target   = tgt_angle;
      case (tassl_pkg::action_type'(action))
         tassl_pkg::ACT_TICK: begin
            result.emit     = 1'b1;
            result.position = tick_angle;
         end
         tassl_pkg::ACT_SET:   result.target = set_clamped;
         tassl_pkg::ACT_NUDGE: result.target = nudge_clamped;
         default: ;
      endcase
      result.command_angle = {1'b0, result.position} + {1'b0, axis_cfg.offset};
   end

endmodule

FILE: rtl/two_axis_servo_slew_limiter.sv
// Two-axis servo slew limiter: input register, axis state, step logic, result register.
// Depends on tassl_pkg, tassl_csr, tassl_step and the defines header.
//
// Usage:
//   Requests arrive on req_* (valid/ready). Action tick moves the axis's
//   current angle up to one slew step toward its target and returns one response
//   on rsp_* carrying the axis, current angle plus offset, current angle and
//   target. Set and nudge change the target and return nothing.
//   Configuration is written through csr_write_enable/csr_index/csr_write_data
//   while the block is idle; writes take effect on the next cycle.
// Timing:
//   A request is registered in the input register on acceptance and processed
//   there; a tick waits there while the result register holds an untaken
//   response, and its response is then registered in the result register.
//   One request per cycle is accepted, set by the single input register
//   and the single result register, as long as responses are taken.
// Reset:
//   Both axes return to 90 for current and target; registers take their
//   default windows, offsets and a step of one. Reset is synchronous.
// Stall:
//   A waiting response holds in the result register; set and nudge requests
//   keep flowing, but a tick holds in the input register, with req_ready low,
//   until the result register frees.
`include "two_axis_servo_slew_limiter_defines.svh"

module two_axis_servo_slew_limiter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_action,
   input  logic                                    req_axis,
   input  logic [tassl_pkg::AngleWidth-1:0]        req_target_request,
   input  logic signed [tassl_pkg::NudgeWidth-1:0] req_nudge,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_out_axis,
   output logic [tassl_pkg::CmdWidth-1:0]          rsp_command_angle,
   output logic [tassl_pkg::AngleWidth-1:0]        rsp_position,
   output logic [tassl_pkg::AngleWidth-1:0]        rsp_target,
   input  logic                                    csr_write_enable,
   input  logic [tassl_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [tassl_pkg::CsrDataWidth-1:0]      csr_write_data
);

   tassl_pkg::cfg_type         cfg;
   tassl_pkg::step_result_type result;

   // Input register
   logic                                    s1_valid_ff, s1_valid_in;
   logic [1:0]                              s1_action_ff;
   logic                                    s1_axis_ff;
   tassl_pkg::angle_type                    s1_request_ff;
   logic signed [tassl_pkg::NudgeWidth-1:0] s1_nudge_ff;

   // Axis state
   tassl_pkg::angle_type cur_ff [tassl_pkg::NumAxes];
   tassl_pkg::angle_type cur_in [tassl_pkg::NumAxes];
   tassl_pkg::angle_type tgt_ff [tassl_pkg::NumAxes];
   tassl_pkg::angle_type tgt_in [tassl_pkg::NumAxes];

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_axis_ff;
   logic [tassl_pkg::CmdWidth-1:0]      rsp_command_ff;
   tassl_pkg::angle_type                rsp_position_ff;
   tassl_pkg::angle_type                rsp_target_ff;

   logic fire;
   logic accept;

   tassl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tassl_step u_step (
      .action    (s1_action_ff),
      .request   (s1_request_ff),
      .nudge     (s1_nudge_ff),
      .axis_cfg  (cfg.axis[s1_axis_ff]),
      .slew_step (cfg.slew_step),
      .cur_angle (cur_ff[s1_axis_ff]),
      .tgt_angle (tgt_ff[s1_axis_ff]),
      .result    (result)
   );

   // Advance the registered request unless its response has nowhere to go
   assign fire      = s1_valid_ff && (!result.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the request payload on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff  <= req_action;
         s1_axis_ff    <= req_axis;
         s1_request_ff <= req_target_request;
         s1_nudge_ff   <= req_nudge;
      end
   end

   // Write back the addressed axis when the request fires
   always_comb begin
      cur_in = cur_ff;
      tgt_in = tgt_ff;
      if (fire) begin
         cur_in[s1_axis_ff] = result.position;
         tgt_in[s1_axis_ff] = result.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tassl_pkg::NumAxes; i++) begin
            cur_ff[i] <= tassl_pkg::ResetAngle;
            tgt_ff[i] <= tassl_pkg::ResetAngle;
         end
      end else begin
         cur_ff <= cur_in;
         tgt_ff <= tgt_in;
      end
   end

   // Load the result register on a tick; drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.emit) begin
         rsp_axis_ff     <= s1_axis_ff;
         rsp_command_ff  <= result.command_angle;
         rsp_position_ff <= result.position;
         rsp_target_ff   <= result.target;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_axis      = rsp_axis_ff;
   assign rsp_command_angle = rsp_command_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_target        = rsp_target_ff;

   // A blocked request stays in the input register untouched
   `TASSL_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !fire,
      s1_valid_ff && $stable(s1_action_ff) && $stable(s1_axis_ff),
      "blocked request left the input register")

   // A fired tick shows up as a response with the stepped position
   `TASSL_ASSERT_NEXT(a_tick_response,
      fire && (s1_action_ff == tassl_pkg::ACT_TICK),
      rsp_valid_ff && (rsp_position_ff == $past(result.position)),
      "tick did not produce its response")

   // Set and nudge never move a current angle
   `TASSL_ASSERT_NEXT(a_target_only,
      fire && (s1_action_ff != tassl_pkg::ACT_TICK),
      (cur_ff[0] == $past(cur_ff[0])) && (cur_ff[1] == $past(cur_ff[1])),
      "non-tick request changed a current angle")

endmodule

FILE: sim/two_axis_servo_slew_limiter_tb.sv
// Self-checking testbench for the two-axis servo slew limiter: directed and random requests,
// each tick response compared with an in-bench prediction of both axes.
// Depends on tassl_pkg and the two_axis_servo_slew_limiter RTL.
module two_axis_servo_slew_limiter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tassl_pkg::*;

   localparam logic [1:0] ActUnused      = 2'd3;
   localparam int         ClockPeriod    = 20;
   localparam int         ResetCycles    = 8;
   localparam int         DrainCycles    = 6;
   localparam int         LongHoldCycles = 80;
   localparam int         RandomRequests = 1900;
   localparam int         ChunkRequests  = 100;
   localparam int         TimeoutNs      = 10_000_000;

   typedef logic [CmdWidth-1:0] command_type;

   typedef struct {
      logic        axis;
      command_type command_angle;
      angle_type   position;
      angle_type   target;
   } servo_command_type;

   // DUT ports, all inputs known from time zero
   logic                         clock;
   logic                         reset              = 1'b1;
   logic                         req_valid          = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_action         = '0;
   logic                         req_axis           = 1'b0;
   angle_type                    req_target_request = '0;
   logic signed [NudgeWidth-1:0] req_nudge          = '0;
   logic                         rsp_valid;
   logic                         rsp_ready          = 1'b0;
   logic                         rsp_out_axis;
   command_type                  rsp_command_angle;
   angle_type                    rsp_position;
   angle_type                    rsp_target;
   logic                         csr_write_enable   = 1'b0;
   logic [CsrIndexWidth-1:0]     csr_index          = '0;
   logic [CsrDataWidth-1:0]      csr_write_data     = '0;

   // predicted block state and register copies
   angle_type win_min [NumAxes];
   angle_type win_max [NumAxes];
   angle_type cmd_offset [NumAxes];
   step_type  step_size;
   angle_type axis_position [NumAxes];
   angle_type axis_target [NumAxes];

   servo_command_type pending_commands [$];
   int                mismatch_count = 0;
   int                req_gap_pct    = 0;
   int                rsp_stall_pct  = 0;
   logic              rsp_hold       = 1'b0;
   event              hold_trigger;

   two_axis_servo_slew_limiter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_axis           (req_axis),
      .req_target_request (req_target_request),
      .req_nudge          (req_nudge),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_axis       (rsp_out_axis),
      .rsp_command_angle  (rsp_command_angle),
      .rsp_position       (rsp_position),
      .rsp_target         (rsp_target),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   initial begin
      #(TimeoutNs);
      $display("two_axis_servo_slew_limiter_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void reset_predictor();
      win_min[0]    = ResetMinA;
      win_max[0]    = ResetMaxA;
      cmd_offset[0] = ResetOffA;
      win_min[1]    = ResetMinB;
      win_max[1]    = ResetMaxB;
      cmd_offset[1] = ResetOffB;
      step_size     = ResetStep;
      for (int a = 0; a < NumAxes; a++) begin
         axis_position[a] = ResetAngle;
         axis_target[a]   = ResetAngle;
      end
   endfunction

   // Clamp into the axis window; max is tested first, so an inverted window yields max or min.
   function automatic angle_type clamp_to_window(int value, logic ax);
      if (value > int'(win_max[ax])) return win_max[ax];
      if (value < int'(win_min[ax])) return win_min[ax];
      return angle_type'(value);
   endfunction

   // Advance the predicted axes by one accepted request; queue the command a tick sends.
   function automatic void apply_request(logic [1:0] act, logic ax, angle_type request,
                                         logic signed [NudgeWidth-1:0] nudge);
      int                now;
      int                gap;
      int                stride;
      servo_command_type cmd;
      stride = int'(step_size);
      case (act)
         ACT_SET: begin
            axis_target[ax] = clamp_to_window(int'(request), ax);
         end
         ACT_NUDGE: begin
            axis_target[ax] = clamp_to_window(int'(axis_target[ax]) + int'(nudge) * stride, ax);
         end
         ACT_TICK: begin
            now = int'(axis_position[ax]);
            gap = int'(axis_target[ax]) - now;
            if (gap > stride) begin
               axis_position[ax] = (now + stride > int'(win_max[ax])) ? win_max[ax]
                                                                      : angle_type'(now + stride);
            end else if (gap < -stride) begin
               axis_position[ax] = (now - stride < int'(win_min[ax])) ? win_min[ax]
                                                                      : angle_type'(now - stride);
            end else begin
               axis_position[ax] = axis_target[ax];
            end
            cmd.axis          = ax;
            cmd.command_angle = command_type'(axis_position[ax])
                                + command_type'(cmd_offset[ax]);
            cmd.position      = axis_position[ax];
            cmd.target        = axis_target[ax];
            pending_commands.push_back(cmd);
         end
         default: begin
            // unused code: state stays as it is
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $realtime, msg);
   endtask

   task automatic check_command();
      servo_command_type want;
      if (pending_commands.size() == 0) begin
         report_mismatch($sformatf("response with none expected: axis %0d command %0d",
                                   rsp_out_axis, rsp_command_angle));
      end else begin
         want = pending_commands.pop_front();
         if (rsp_out_axis !== want.axis)
            report_mismatch($sformatf("axis %0b, expected %0b", rsp_out_axis, want.axis));
         if (rsp_command_angle !== want.command_angle)
            report_mismatch($sformatf("command_angle %0d, expected %0d",
                                      rsp_command_angle, want.command_angle));
         if (rsp_position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d", rsp_position, want.position));
         if (rsp_target !== want.target)
            report_mismatch($sformatf("target %0d, expected %0d", rsp_target, want.target));
      end
   endtask

   // Take responses and decide the next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_command();
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Hold off the response side for a long stretch when triggered
   initial begin
      forever begin
         @(hold_trigger);
         rsp_hold <= 1'b1;
         repeat (LongHoldCycles) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_request(logic [1:0] act, logic ax, angle_type request,
                               logic signed [NudgeWidth-1:0] nudge);
      // idle at random, then offer and hold until accepted
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act;
      req_axis           <= ax;
      req_target_request <= request;
      req_nudge          <= nudge;
      do @(posedge clock); while (!req_ready);
      apply_request(act, ax, request, nudge);
   endtask

   // Drop valid, wait for every response, then let any set or nudge settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_MIN_A:     win_min[0]    = data;
         CSR_MAX_A:     win_max[0]    = data;
         CSR_OFFSET_A:  cmd_offset[0] = data;
         CSR_MIN_B:     win_min[1]    = data;
         CSR_MAX_B:     win_max[1]    = data;
         CSR_OFFSET_B:  cmd_offset[1] = data;
         CSR_SLEW_STEP: step_size     = data[StepWidth-1:0];
         default: ;
      endcase
   endtask

   // Write all registers back to back; call only with the block idle
   task automatic apply_settings(angle_type min_a, angle_type max_a, angle_type off_a,
                                 angle_type min_b, angle_type max_b, angle_type off_b,
                                 logic [CsrDataWidth-1:0] step);
      write_register(CSR_MIN_A, min_a);
      write_register(CSR_MAX_A, max_a);
      write_register(CSR_OFFSET_A, off_a);
      write_register(CSR_MIN_B, min_b);
      write_register(CSR_MAX_B, max_b);
      write_register(CSR_OFFSET_B, off_b);
      write_register(CSR_SLEW_STEP, step);
      csr_write_enable <= 1'b0;
   endtask

   task automatic randomize_settings();
      angle_type               lo [NumAxes];
      angle_type               hi [NumAxes];
      angle_type               off [NumAxes];
      angle_type               swap;
      logic [CsrDataWidth-1:0] step;
      for (int a = 0; a < NumAxes; a++) begin
         lo[a] = angle_type'($urandom_range(200));
         hi[a] = angle_type'($urandom_range(255, lo[a]));
         // invert the window now and then
         if ($urandom_range(9) == 0) begin
            swap  = lo[a];
            lo[a] = hi[a];
            hi[a] = swap;
         end
         off[a] = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(180));
      end
      case ($urandom_range(9))
         0:       step = 8'd0;
         1:       step = {1'($urandom_range(1)), 7'd127};
         2, 3:    step = 8'($urandom_range(90, 1));
         default: step = 8'($urandom_range(8, 1));
      endcase
      apply_settings(lo[0], hi[0], off[0], lo[1], hi[1], off[1], step);
   endtask

   task automatic send_random_request(output bit counted);
      logic [1:0]                   act;
      logic                         ax;
      angle_type                    request;
      logic signed [NudgeWidth-1:0] nudge;
      int                           pick;
      pick = $urandom_range(99);
      if (pick < 50)      act = ACT_TICK;
      else if (pick < 72) act = ACT_SET;
      else if (pick < 95) act = ACT_NUDGE;
      else                act = ActUnused;
      ax      = 1'($urandom_range(1));
      request = angle_type'($urandom_range(255));
      // mostly small nudges so targets are not always pinned to an edge
      nudge   = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8) - 4);
      send_request(act, ax, request, nudge);
      counted = (act != ActUnused);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      // reset angles and default windows, plus an unused code that must do nothing
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b1, 8'd0, 8'sd0);
      send_request(ActUnused, 1'b1, 8'hFF, -8'sd1);
      send_request(ACT_TICK, 1'b1, 8'd0, 8'sd0);
   endtask

   task automatic test_set_target_clamp();
      wait_for_idle();
      apply_settings(8'd0, 8'd255, 8'd180, 8'd40, 8'd200, 8'd0, 8'd90);
      send_request(ACT_SET, 1'b0, 8'd255, 8'sd0);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_SET, 1'b1, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b1, 8'd0, 8'sd0);
      send_request(ACT_SET, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
   endtask

   task automatic test_nudge_extremes();
      wait_for_idle();
      apply_settings(8'd10, 8'd250, 8'd255, 8'd0, 8'd255, 8'd0, 8'd90);
      send_request(ACT_NUDGE, 1'b0, 8'd0, 8'sd127);
      send_request(ACT_NUDGE, 1'b1, 8'd0, -8'sd128);
      send_request(ACT_NUDGE, 1'b1, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b1, 8'd0, 8'sd0);
   endtask

   task automatic test_inverted_window();
      wait_for_idle();
      apply_settings(8'd200, 8'd50, 8'd0, 8'd255, 8'd0, 8'd7, 8'd3);
      send_request(ACT_SET, 1'b0, 8'd100, 8'sd0);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_NUDGE, 1'b1, 8'd0, 8'sd1);
      send_request(ACT_TICK, 1'b1, 8'd0, 8'sd0);
   endtask

   task automatic test_step_extremes();
      // zero step, then the widest step written with the unused top bit set
      wait_for_idle();
      apply_settings(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd180, 8'd0);
      send_request(ACT_SET, 1'b0, 8'd255, 8'sd0);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      wait_for_idle();
      apply_settings(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd180, 8'hFF);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b0, 8'd0, 8'sd0);
      send_request(ACT_SET, 1'b1, 8'd0, 8'sd0);
      send_request(ACT_TICK, 1'b1, 8'd0, 8'sd0);
   endtask

   task automatic test_response_backpressure();
      // hold responses off while ticks keep coming, so the input side stalls
      wait_for_idle();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      -> hold_trigger;
      for (int i = 0; i < 40; i++) begin
         if (i % 5 == 4)
            send_request(ACT_SET, 1'($urandom_range(1)), 8'($urandom_range(255)), 8'sd0);
         else
            send_request(ACT_TICK, 1'($urandom_range(1)), 8'd0, 8'sd0);
      end
      wait_for_idle();
   endtask

   task automatic run_random_phase(int gap_pct, int stall_pct, int requests);
      int done;
      bit counted;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      done          = 0;
      while (done < requests) begin
         wait_for_idle();
         randomize_settings();
         for (int i = 0; i < ChunkRequests && done < requests; i++) begin
            send_random_request(counted);
            if (counted) done++;
         end
      end
   endtask

   task automatic test_random_requests();
      run_random_phase(12, 78, RandomRequests / 3);
      run_random_phase(78, 12, RandomRequests / 3);
      run_random_phase(0, 0, RandomRequests - 2 * (RandomRequests / 3));
   endtask

   task automatic finish_run();
      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("two_axis_servo_slew_limiter_tb passed");
      end else begin
         $display("two_axis_servo_slew_limiter_tb failed");
      end
      $finish;
   endtask

   initial begin
      reset_predictor();
      repeat (ResetCycles) @(posedge clock);
      reset         <= 1'b0;
      req_gap_pct   = 12;
      rsp_stall_pct = 78;
      test_reset_state();
      test_set_target_clamp();
      test_nudge_extremes();
      test_inverted_window();
      test_step_extremes();
      test_response_backpressure();
      test_random_requests();
      finish_run();
   end

endmodule
